### rtl/lcdcw_pkg.sv
package lcdcw_pkg;

  // default panel size
  localparam int unsigned PANEL_WIDTH_DEF  = 320;
  localparam int unsigned PANEL_HEIGHT_DEF = 240;

  // command codes
  localparam logic [7:0] CMD_NOP     = 8'h00;
  localparam logic [7:0] CMD_SWRESET = 8'h01;
  localparam logic [7:0] CMD_SLPIN   = 8'h10;
  localparam logic [7:0] CMD_SLPOUT  = 8'h11;
  localparam logic [7:0] CMD_INVOFF  = 8'h20;
  localparam logic [7:0] CMD_INVON   = 8'h21;
  localparam logic [7:0] CMD_DISPOFF = 8'h28;
  localparam logic [7:0] CMD_DISPON  = 8'h29;
  localparam logic [7:0] CMD_CASET   = 8'h2a;
  localparam logic [7:0] CMD_RASET   = 8'h2b;
  localparam logic [7:0] CMD_RAMWR   = 8'h2c;
  localparam logic [7:0] CMD_MADCTL  = 8'h36;
  localparam logic [7:0] CMD_COLMOD  = 8'h3a;
  localparam logic [7:0] CMD_RAMCTRL = 8'hb0;

  // register reset values and masks
  localparam logic [7:0] COLMOD_RESET  = 8'h55;
  localparam logic [7:0] COLMOD_MASK   = 8'h77;
  localparam logic [7:0] COLMOD_16BIT  = 8'h55;
  localparam logic [7:0] RAMCTRL_RESET = 8'hf0;

  // bit positions
  localparam int unsigned RAMCTRL_LE_BIT = 3;
  localparam int unsigned MADCTL_BGR_BIT = 3;
  localparam int unsigned FLAG_ON        = 0;
  localparam int unsigned FLAG_SLEEP     = 1;
  localparam int unsigned FLAG_INV       = 2;
  localparam int unsigned FLAG_LE        = 3;
  localparam logic [3:0]  FLAGS_RESET    = 4'b0010;

  // tdata width of the result beat
  localparam int unsigned RES_BITS       = 38;
  localparam int unsigned RES_TDATA_BITS = 40;

  // one result beat as produced by the core
  typedef struct packed {
    logic        blue_first;
    logic        colour_inverted;
    logic        asleep;
    logic        panel_on;
    logic        clear_frame;
    logic [15:0] pixel_value;
    logic [8:0]  pixel_column;
    logic [7:0]  pixel_row;
    logic        pixel_write;
  } result_t;

  // number of argument bytes a command takes
  function automatic logic [2:0] args_needed(input logic [7:0] cmd);
    logic [2:0] n;
    begin
      case (cmd)
        CMD_CASET, CMD_RASET:   n = 3'd4;
        CMD_MADCTL, CMD_COLMOD: n = 3'd1;
        CMD_RAMCTRL:            n = 3'd2;
        default:                n = 3'd0;
      endcase
      return n;
    end
  endfunction

endpackage

### rtl/lcdcw_core.sv
module lcdcw_core #(
  parameter int unsigned PANEL_WIDTH  = lcdcw_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT = lcdcw_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                is_data_i,
  input  logic [7:0]          serial_byte_i,
  output lcdcw_pkg::result_t  result_o
);

  localparam logic [15:0] PanelW   = 16'(PANEL_WIDTH);
  localparam logic [15:0] PanelH   = 16'(PANEL_HEIGHT);
  localparam logic [15:0] ColEndRst = 16'(PANEL_WIDTH - 1);
  localparam logic [15:0] RowEndRst = 16'(PANEL_HEIGHT - 1);

  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  arg_q [4];
  logic [7:0]  arg_d [4];
  logic [2:0]  cnt_q, cnt_d;
  logic        half_q, half_d;
  logic [7:0]  madctl_q, madctl_d;
  logic [7:0]  colmod_q, colmod_d;
  logic [7:0]  ramctrl_q, ramctrl_d;
  logic [3:0]  flags_q, flags_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [15:0] col_start_q, col_start_d;
  logic [15:0] col_end_q, col_end_d;
  logic [15:0] row_base_q, row_base_d;
  logic [15:0] row_end_q, row_end_d;

  logic [2:0]  need;
  logic [15:0] pix;
  logic [15:0] col_inc;
  logic [15:0] row_inc;
  logic        in_panel;
  logic        fmt_ok;
  lcdcw_pkg::result_t res;

  assign need     = lcdcw_pkg::args_needed(cmd_q);
  assign fmt_ok   = (colmod_q & lcdcw_pkg::COLMOD_MASK) == lcdcw_pkg::COLMOD_16BIT;
  assign in_panel = (col_q < PanelW) && (row_q < PanelH);
  assign col_inc  = col_q + 16'd1;
  assign row_inc  = row_q + 16'd1;
  assign pix      = flags_q[lcdcw_pkg::FLAG_LE] ? {serial_byte_i, arg_q[0]}
                                                : {arg_q[0], serial_byte_i};

  // byte decode, argument collection and pixel assembly
  always_comb begin
    cmd_d       = cmd_q;
    arg_d       = arg_q;
    cnt_d       = cnt_q;
    half_d      = half_q;
    madctl_d    = madctl_q;
    colmod_d    = colmod_q;
    ramctrl_d   = ramctrl_q;
    flags_d     = flags_q;
    col_d       = col_q;
    row_d       = row_q;
    col_start_d = col_start_q;
    col_end_d   = col_end_q;
    row_base_d  = row_base_q;
    row_end_d   = row_end_q;
    res         = '0;

    if (!is_data_i) begin
      cmd_d  = serial_byte_i;
      cnt_d  = 3'd0;
      half_d = 1'b0;
      case (serial_byte_i)
        lcdcw_pkg::CMD_SWRESET: begin
          cmd_d           = lcdcw_pkg::CMD_NOP;
          madctl_d        = 8'h00;
          colmod_d        = lcdcw_pkg::COLMOD_RESET;
          ramctrl_d       = lcdcw_pkg::RAMCTRL_RESET;
          flags_d         = lcdcw_pkg::FLAGS_RESET;
          col_d           = 16'd0;
          row_d           = 16'd0;
          col_start_d     = 16'd0;
          col_end_d       = ColEndRst;
          row_base_d      = 16'd0;
          row_end_d       = RowEndRst;
          res.clear_frame = 1'b1;
        end
        lcdcw_pkg::CMD_SLPIN:   flags_d[lcdcw_pkg::FLAG_SLEEP] = 1'b1;
        lcdcw_pkg::CMD_SLPOUT:  flags_d[lcdcw_pkg::FLAG_SLEEP] = 1'b0;
        lcdcw_pkg::CMD_INVOFF:  flags_d[lcdcw_pkg::FLAG_INV]   = 1'b0;
        lcdcw_pkg::CMD_INVON:   flags_d[lcdcw_pkg::FLAG_INV]   = 1'b1;
        lcdcw_pkg::CMD_DISPOFF: flags_d[lcdcw_pkg::FLAG_ON]    = 1'b0;
        lcdcw_pkg::CMD_DISPON:  flags_d[lcdcw_pkg::FLAG_ON]    = 1'b1;
        default: ;
      endcase
    end else if (cmd_q == lcdcw_pkg::CMD_RAMWR) begin
      if (fmt_ok) begin
        if (!half_q) begin
          arg_d[0] = serial_byte_i;
          half_d   = 1'b1;
        end else begin
          half_d = 1'b0;
          if (in_panel) begin
            res.pixel_write  = 1'b1;
            res.pixel_row    = row_q[7:0];
            res.pixel_column = col_q[8:0];
            res.pixel_value  = pix;
          end
          // advance and wrap inside the window
          if (col_inc > col_end_q) begin
            col_d = col_start_q;
            row_d = (row_inc > row_end_q) ? row_base_q : row_inc;
          end else begin
            col_d = col_inc;
          end
        end
      end
    end else if (cnt_q < need) begin
      arg_d[cnt_q[1:0]] = serial_byte_i;
      cnt_d             = cnt_q + 3'd1;
      if (cnt_d == need) begin
        case (cmd_q)
          lcdcw_pkg::CMD_CASET: begin
            col_start_d = {arg_d[0], arg_d[1]};
            col_end_d   = {arg_d[2], arg_d[3]};
            col_d       = {arg_d[0], arg_d[1]};
          end
          lcdcw_pkg::CMD_RASET: begin
            row_base_d  = {arg_d[0], arg_d[1]};
            row_end_d   = {arg_d[2], arg_d[3]};
            row_d       = {arg_d[0], arg_d[1]};
          end
          lcdcw_pkg::CMD_MADCTL: madctl_d = arg_d[0];
          lcdcw_pkg::CMD_COLMOD: colmod_d = arg_d[0];
          lcdcw_pkg::CMD_RAMCTRL: begin
            ramctrl_d                   = arg_d[1];
            flags_d[lcdcw_pkg::FLAG_LE] = arg_d[1][lcdcw_pkg::RAMCTRL_LE_BIT];
          end
          default: ;
        endcase
      end
    end

    // status after this byte
    res.panel_on        = flags_d[lcdcw_pkg::FLAG_ON];
    res.asleep          = flags_d[lcdcw_pkg::FLAG_SLEEP];
    res.colour_inverted = flags_d[lcdcw_pkg::FLAG_INV];
    res.blue_first      = madctl_d[lcdcw_pkg::MADCTL_BGR_BIT];
  end

  assign result_o = res;

  // control and mode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= lcdcw_pkg::CMD_NOP;
      cnt_q       <= 3'd0;
      half_q      <= 1'b0;
      madctl_q    <= 8'h00;
      colmod_q    <= lcdcw_pkg::COLMOD_RESET;
      ramctrl_q   <= lcdcw_pkg::RAMCTRL_RESET;
      flags_q     <= lcdcw_pkg::FLAGS_RESET;
      col_q       <= 16'd0;
      row_q       <= 16'd0;
      col_start_q <= 16'd0;
      col_end_q   <= ColEndRst;
      row_base_q  <= 16'd0;
      row_end_q   <= RowEndRst;
    end else if (step_i) begin
      cmd_q       <= cmd_d;
      cnt_q       <= cnt_d;
      half_q      <= half_d;
      madctl_q    <= madctl_d;
      colmod_q    <= colmod_d;
      ramctrl_q   <= ramctrl_d;
      flags_q     <= flags_d;
      col_q       <= col_d;
      row_q       <= row_d;
      col_start_q <= col_start_d;
      col_end_q   <= col_end_d;
      row_base_q  <= row_base_d;
      row_end_q   <= row_end_d;
    end
  end

  // argument bytes, no reset
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      arg_q <= arg_d;
    end
  end

endmodule

### rtl/lcd_command_window_writer_unit.sv
// Serial front end of a small LCD controller: each input beat is one byte with its
// data/command line (tuser), and each beat yields exactly one result beat carrying an
// optional frame-store pixel write, a frame-clear request on software reset and the
// current mode flags. It takes one beat per clock cycle while its output buffer has
// room; each result is registered in the output register, via the skid register on a
// stall, with all decode and window-address arithmetic between the state and result
// registers. The two-entry buffer keeps input ready high while one result waits, so
// a stall holds off input only with two results pending. The frame store is external.
module lcd_command_window_writer_unit #(
  parameter int unsigned PANEL_WIDTH  = lcdcw_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT = lcdcw_pkg::PANEL_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] serial_byte
  input  logic        s_axis_tuser,   // [0] is_data
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] pixel_row, [16:8] pixel_column, [32:17] pixel_value, [33] clear_frame,
  // [34] panel_on, [35] asleep, [36] colour_inverted, [37] blue_first, [39:38] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tuser    // [0] pixel_write
);

  logic               accept;
  lcdcw_pkg::result_t res;
  lcdcw_pkg::result_t out_q, out_d;
  lcdcw_pkg::result_t skid_q, skid_d;
  logic               out_valid_q, out_valid_d;
  logic               skid_valid_q, skid_valid_d;

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lcdcw_core #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .is_data_i     (s_axis_tuser),
    .serial_byte_i (s_axis_tdata),
    .result_o      (res)
  );

  // output register with skid stage
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (m_axis_tready || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (accept) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (accept) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // pack the result beat
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.pixel_write;
  assign m_axis_tdata  = {
    2'b00,
    out_q.blue_first,
    out_q.colour_inverted,
    out_q.asleep,
    out_q.panel_on,
    out_q.clear_frame,
    out_q.pixel_value,
    out_q.pixel_column,
    out_q.pixel_row
  };

endmodule

### rtl/lcdcw_checker.sv
module lcdcw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a held result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // a pixel write never comes together with a frame clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[33])
    else $error("pixel write together with frame clear");

  // software reset leaves the mode flags at their reset values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33] |->
      !m_axis_tdata[34] && m_axis_tdata[35] && !m_axis_tdata[36] && !m_axis_tdata[37])
    else $error("mode flags wrong after software reset");

  // without a pixel write the pixel fields are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[32:0] == 33'd0)
    else $error("pixel fields set without a write");

  // input is only held off while a result is waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind lcd_command_window_writer_unit lcdcw_checker u_lcdcw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### test/tb_lcd_command_window_writer_unit.sv
module tb_lcd_command_window_writer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdcw_pkg::*;

  // a command code that the block does not know
  localparam logic [7:0] CMD_UNUSED = 8'hff;

  typedef struct packed {
    logic       is_data;
    logic [7:0] value;
  } serial_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] serial_byte
  logic        s_axis_tuser = 1'b0; // [0] is_data
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] pixel_row, [16:8] pixel_column, [32:17] pixel_value, [33] clear_frame,
  // [34] panel_on, [35] asleep, [36] colour_inverted, [37] blue_first
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;        // [0] pixel_write

  // byte stream waiting to be sent and result beats still owed by the block
  serial_beat_t        byte_queue[$];
  result_t             due_results[$];
  serial_beat_t        next_beat;
  result_t             want;
  int unsigned         error_count = 0;
  int unsigned         send_gap = 0;
  int unsigned         take_gap = 0;
  int unsigned         beats_queued = 0;
  int unsigned         noise_beats = 0;
  logic                stim_loaded = 1'b0;
  logic                calm_tail = 1'b0;

  // shadow of the controller state
  logic [7:0]  cur_cmd;
  logic [7:0]  arg_buf[4];
  int unsigned arg_cnt;
  logic        half_pending;
  logic [7:0]  madctl;
  logic [7:0]  colmod;
  logic [7:0]  ramctrl;
  logic [3:0]  flags;
  logic [15:0] addr_col;
  logic [15:0] addr_row;
  logic [15:0] col_start;
  logic [15:0] col_end;
  logic [15:0] row_base;
  logic [15:0] row_end;

  lcd_command_window_writer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // power-on and software reset values (argument buffer is kept)
  task automatic restore_defaults();
    begin
      cur_cmd      = CMD_NOP;
      arg_cnt      = 0;
      half_pending = 1'b0;
      madctl       = 8'h00;
      colmod       = COLMOD_RESET;
      ramctrl      = RAMCTRL_RESET;
      flags        = FLAGS_RESET;
      addr_col     = '0;
      addr_row     = '0;
      col_start    = '0;
      col_end      = 16'(PANEL_WIDTH_DEF - 1);
      row_base     = '0;
      row_end      = 16'(PANEL_HEIGHT_DEF - 1);
    end
  endtask

  // effect of one serial byte: updates the shadow state, queues the owed beat
  task automatic decode_serial_byte(input logic is_data, input logic [7:0] b);
    result_t     r;
    logic [15:0] pix;
    int unsigned need;
    begin
      r = '0;
      if (!is_data) begin
        cur_cmd      = b;
        arg_cnt      = 0;
        half_pending = 1'b0;
        case (b)
          CMD_SWRESET: begin
            restore_defaults();
            r.clear_frame = 1'b1;
          end
          CMD_SLPIN:   flags[FLAG_SLEEP] = 1'b1;
          CMD_SLPOUT:  flags[FLAG_SLEEP] = 1'b0;
          CMD_INVOFF:  flags[FLAG_INV] = 1'b0;
          CMD_INVON:   flags[FLAG_INV] = 1'b1;
          CMD_DISPOFF: flags[FLAG_ON] = 1'b0;
          CMD_DISPON:  flags[FLAG_ON] = 1'b1;
          default: ;
        endcase
      end else if (cur_cmd == CMD_RAMWR) begin
        // pixel bytes only count in 16-bit format
        if ((colmod & COLMOD_MASK) == COLMOD_16BIT) begin
          if (!half_pending) begin
            arg_buf[0]   = b;
            half_pending = 1'b1;
          end else begin
            pix = flags[FLAG_LE] ? {b, arg_buf[0]} : {arg_buf[0], b};
            half_pending = 1'b0;
            if (addr_col < PANEL_WIDTH_DEF && addr_row < PANEL_HEIGHT_DEF) begin
              r.pixel_write  = 1'b1;
              r.pixel_row    = addr_row[7:0];
              r.pixel_column = addr_col[8:0];
              r.pixel_value  = pix;
            end
            // step through the window, wrapping column then row
            addr_col = addr_col + 16'd1;
            if (addr_col > col_end) begin
              addr_col = col_start;
              addr_row = addr_row + 16'd1;
              if (addr_row > row_end) addr_row = row_base;
            end
          end
        end
      end else begin
        case (cur_cmd)
          CMD_CASET, CMD_RASET:   need = 4;
          CMD_MADCTL, CMD_COLMOD: need = 1;
          CMD_RAMCTRL:            need = 2;
          default:                need = 0;
        endcase
        // collect arguments, apply on the last one, drop any surplus
        if (arg_cnt < need) begin
          arg_buf[arg_cnt] = b;
          arg_cnt++;
          if (arg_cnt == need) begin
            case (cur_cmd)
              CMD_CASET: begin
                col_start = {arg_buf[0], arg_buf[1]};
                col_end   = {arg_buf[2], arg_buf[3]};
                addr_col  = col_start;
              end
              CMD_RASET: begin
                row_base  = {arg_buf[0], arg_buf[1]};
                row_end   = {arg_buf[2], arg_buf[3]};
                addr_row  = row_base;
              end
              CMD_MADCTL: madctl = arg_buf[0];
              CMD_COLMOD: colmod = arg_buf[0];
              CMD_RAMCTRL: begin
                ramctrl        = arg_buf[1];
                flags[FLAG_LE] = ramctrl[RAMCTRL_LE_BIT];
              end
              default: ;
            endcase
          end
        end
      end
      r.panel_on        = flags[FLAG_ON];
      r.asleep          = flags[FLAG_SLEEP];
      r.colour_inverted = flags[FLAG_INV];
      r.blue_first      = madctl[MADCTL_BGR_BIT];
      due_results.push_back(r);
    end
  endtask

  task automatic push_beat(input logic is_data, input logic [7:0] b);
    serial_beat_t sb;
    begin
      sb.is_data = is_data;
      sb.value   = b;
      byte_queue.push_back(sb);
      beats_queued++;
    end
  endtask

  task automatic push_window(input logic [7:0] cmd, input logic [15:0] lo,
                             input logic [15:0] hi);
    begin
      push_beat(1'b0, cmd);
      push_beat(1'b1, lo[15:8]);
      push_beat(1'b1, lo[7:0]);
      push_beat(1'b1, hi[15:8]);
      push_beat(1'b1, hi[7:0]);
    end
  endtask

  // mostly small windows starting inside or just past the panel, sometimes anything at all
  function automatic logic [31:0] random_window(input int unsigned extent);
    logic [15:0] lo;
    logic [15:0] hi;
    begin
      if ($urandom_range(0, 9) < 8) begin
        lo = 16'($urandom_range(0, extent + 4));
        hi = lo + 16'($urandom_range(0, 5));
      end else begin
        lo = 16'($urandom);
        hi = 16'($urandom);
      end
      return {lo, hi};
    end
  endfunction

  task automatic check_field(input string what, input int unsigned want_v,
                             input int unsigned got_v);
    begin
      if (want_v != got_v) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want_v, got_v);
        error_count++;
      end
    end
  endtask

  task automatic wait_drained();
    begin
      do @(negedge clk_i);
      while (byte_queue.size() != 0 || s_axis_tvalid || due_results.size() != 0);
    end
  endtask

  // byte sender with random idle bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_serial_byte(s_axis_tuser, s_axis_tdata);
      end
      calm_tail <= stim_loaded && (byte_queue.size() < 100);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap == 0 && !calm_tail && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 12);
        end
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          next_beat = byte_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_beat.value;
          s_axis_tuser  <= next_beat.is_data;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver with random stall bursts, checks every beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      take_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result beat with none expected, actual tdata 0x%0h tuser %0b",
                   $time, m_axis_tdata, m_axis_tuser);
          error_count++;
        end else begin
          want = due_results.pop_front();
          check_field("pixel_write", want.pixel_write, m_axis_tuser);
          check_field("pixel_row", want.pixel_row, m_axis_tdata[7:0]);
          check_field("pixel_column", want.pixel_column, m_axis_tdata[16:8]);
          check_field("pixel_value", want.pixel_value, m_axis_tdata[32:17]);
          check_field("clear_frame", want.clear_frame, m_axis_tdata[33]);
          check_field("panel_on", want.panel_on, m_axis_tdata[34]);
          check_field("asleep", want.asleep, m_axis_tdata[35]);
          check_field("colour_inverted", want.colour_inverted, m_axis_tdata[36]);
          check_field("blue_first", want.blue_first, m_axis_tdata[37]);
        end
      end
      if (take_gap == 0 && !calm_tail && $urandom_range(0, 7) == 0) begin
        take_gap = $urandom_range(1, 12);
      end
      if (take_gap > 0) begin
        take_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // stimulus: directed bytes, then random command sequences
  initial begin
    int unsigned pick;
    int unsigned n;
    logic [31:0] w;
    logic        paused;

    paused = 1'b0;
    restore_defaults();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // data byte before any command, then the flag commands
    push_beat(1'b1, 8'h00);
    push_beat(1'b0, CMD_SLPOUT);
    push_beat(1'b0, CMD_DISPON);
    push_beat(1'b0, CMD_INVON);
    push_beat(1'b0, CMD_MADCTL);
    push_beat(1'b1, 8'hff);
    // window straddling the right panel edge, plus a surplus argument
    push_window(CMD_CASET, 16'h013f, 16'h0140);
    push_beat(1'b1, 8'hff);
    // big-endian pixels: one inside the panel, one outside, then wrap
    push_beat(1'b0, CMD_RAMWR);
    push_beat(1'b1, 8'haa);
    push_beat(1'b1, 8'h55);
    push_beat(1'b1, 8'h00);
    push_beat(1'b1, 8'hff);
    // little-endian pixel
    push_beat(1'b0, CMD_RAMCTRL);
    push_beat(1'b1, 8'h00);
    push_beat(1'b1, 8'h08);
    push_beat(1'b0, CMD_RAMWR);
    push_beat(1'b1, 8'h34);
    push_beat(1'b1, 8'h12);
    // non-16-bit format drops pixel data
    push_beat(1'b0, CMD_COLMOD);
    push_beat(1'b1, 8'h66);
    push_beat(1'b0, CMD_RAMWR);
    push_beat(1'b1, 8'h12);
    push_beat(1'b1, 8'h34);
    // unknown command with data, then software reset
    push_beat(1'b0, CMD_UNUSED);
    push_beat(1'b1, 8'h01);
    push_beat(1'b0, CMD_SWRESET);
    wait_drained();

    beats_queued = 0;
    while (beats_queued - noise_beats < 600) begin
      // hold the sender once until every result is back
      if (!paused && beats_queued - noise_beats >= 300) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        w = random_window(PANEL_WIDTH_DEF);
        push_window(CMD_CASET, w[31:16], w[15:0]);
      end else if (pick < 24) begin
        w = random_window(PANEL_HEIGHT_DEF);
        push_window(CMD_RASET, w[31:16], w[15:0]);
      end else if (pick < 55) begin
        push_beat(1'b0, CMD_RAMWR);
        n = ($urandom_range(0, 9) < 8) ? 2 * $urandom_range(1, 8) : $urandom_range(0, 15);
        repeat (n) push_beat(1'b1, 8'($urandom));
      end else if (pick < 62) begin
        push_beat(1'b0, CMD_COLMOD);
        if ($urandom_range(0, 9) < 7) begin
          push_beat(1'b1, COLMOD_16BIT | (8'($urandom) & ~COLMOD_MASK));
        end else begin
          push_beat(1'b1, 8'($urandom));
        end
      end else if (pick < 68) begin
        push_beat(1'b0, CMD_RAMCTRL);
        push_beat(1'b1, 8'($urandom));
        push_beat(1'b1, 8'($urandom));
      end else if (pick < 73) begin
        push_beat(1'b0, CMD_MADCTL);
        push_beat(1'b1, 8'($urandom));
      end else if (pick < 85) begin
        case ($urandom_range(0, 6))
          0: push_beat(1'b0, CMD_SLPIN);
          1: push_beat(1'b0, CMD_SLPOUT);
          2: push_beat(1'b0, CMD_INVOFF);
          3: push_beat(1'b0, CMD_INVON);
          4: push_beat(1'b0, CMD_DISPOFF);
          5: push_beat(1'b0, CMD_DISPON);
          default: push_beat(1'b0, CMD_NOP);
        endcase
      end else if (pick < 88) begin
        push_beat(1'b0, CMD_SWRESET);
      end else begin
        // noise: any command, truncated or overlong argument runs
        n = $urandom_range(1, 5);
        noise_beats += n;
        push_beat(1'b0, 8'($urandom));
        repeat (n - 1) push_beat(1'($urandom), 8'($urandom));
      end
    end
    stim_loaded = 1'b1;

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
